// File: hw/rtl/bdpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared constants for the button debounce and press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_LEVEL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLICK_MS    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RESTART_MS  = 2'd3;
	localparam int unsigned CFG_DATA_W = 32;

	// reset values of the registers
	localparam logic        IDLE_LEVEL_RST  = 1'b1;
	localparam logic [15:0] DEBOUNCE_MS_RST = 16'd20;
	localparam logic [15:0] CLICK_MS_RST    = 16'd400;
	localparam logic [31:0] RESTART_MS_RST  = 32'd15000;

	// event codes
	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_PRESS   = 2'd1;
	localparam logic [1:0] EV_RELEASE = 2'd2;
	localparam logic [1:0] EV_RESTART = 2'd3;

endpackage

// File: hw/rtl/bdpc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_in_if / bdpc_out_if
// Valid/ready channels for button samples and classified results.
// ----------------------------------------------------------------------------
interface bdpc_in_if;
	logic        valid;
	logic        ready;
	logic        sample_level;
	logic [31:0] now_ms;

	modport source (output valid, output sample_level, output now_ms, input ready);
	modport sink   (input valid, input sample_level, input now_ms, output ready);
endinterface

interface bdpc_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_code;
	logic       short_click;
	logic       pushed;

	modport source (output valid, output event_code, output short_click, output pushed,
		input ready);
	modport sink   (input valid, input event_code, input short_click, input pushed,
		output ready);
endinterface

// File: hw/rtl/button_debounce_press_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_core
// Debounces sampled button levels and reports press, release, short-click
// and long-hold restart events.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one word per sample: the raw pin level and a free-running
//   millisecond timestamp. out_ch returns exactly one word per sample: an
//   event code, the short-click flag and the current pushed state.
//   Samples are taken into an input register (_s1); the debounce state is
//   evaluated and updated there and the result lands in the output register.
//   An accepted sample passes through the input register and then the output
//   register to out_ch.valid. Throughput is one sample per cycle while out_ch
//   does not stall; it is set by the state update, two 32-bit subtract-and-compare paths on the timestamp.
//   When the receiver stalls, the output register holds its word and the
//   input register still accepts one more sample; in_ch.ready drops once
//   both are full.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the
//   next edge and must only be issued while no sample is in flight.
//   Reset clears both stages, restores the register defaults (idle level 1,
//   debounce 20 ms, click 400 ms, restart 15000 ms) and the debounce state.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bdpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bdpc_pkg::CFG_DATA_W-1:0]    cfg_data,
	bdpc_in_if.sink                            in_ch,
	bdpc_out_if.source                         out_ch
);

	// configuration
	logic        idle_level_q;
	logic [15:0] debounce_ms_q;
	logic [15:0] click_ms_q;
	logic [31:0] restart_ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_level_q  <= bdpc_pkg::IDLE_LEVEL_RST;
			debounce_ms_q <= bdpc_pkg::DEBOUNCE_MS_RST;
			click_ms_q    <= bdpc_pkg::CLICK_MS_RST;
			restart_ms_q  <= bdpc_pkg::RESTART_MS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bdpc_pkg::REG_IDLE_LEVEL:  idle_level_q  <= cfg_data[0];
				bdpc_pkg::REG_DEBOUNCE_MS: debounce_ms_q <= cfg_data[15:0];
				bdpc_pkg::REG_CLICK_MS:    click_ms_q    <= cfg_data[15:0];
				bdpc_pkg::REG_RESTART_MS:  restart_ms_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// pipeline control
	logic        v_s1;
	logic        level_s1;
	logic [31:0] now_s1;
	logic        out_v_q;
	logic        adv_s1;

	assign adv_s1      = !out_v_q || out_ch.ready;
	assign in_ch.ready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			level_s1 <= in_ch.sample_level;
			now_s1   <= in_ch.now_ms;
		end
	end

	// debounce state
	logic        stable_q;
	logic        cand_q;
	logic [31:0] cand_start_q;
	logic [31:0] press_start_q;
	logic        restart_fired_q;

	logic        stable_d;
	logic        cand_d;
	logic [31:0] cand_start_d;
	logic [31:0] press_start_d;
	logic        restart_fired_d;
	logic [1:0]  event_d;
	logic        short_d;
	logic [31:0] held;
	logic [31:0] cand_age;

	assign held     = now_s1 - press_start_q;
	assign cand_age = now_s1 - cand_start_q;

	always_comb begin
		stable_d        = stable_q;
		cand_d          = cand_q;
		cand_start_d    = cand_start_q;
		press_start_d   = press_start_q;
		restart_fired_d = restart_fired_q;
		event_d         = bdpc_pkg::EV_NONE;
		short_d         = 1'b0;
		priority if (stable_q == cand_q) begin
			if (level_s1 == cand_q) begin
				if (level_s1 != idle_level_q && held > restart_ms_q && !restart_fired_q) begin
					restart_fired_d = 1'b1;
					event_d         = bdpc_pkg::EV_RESTART;
				end
			end else begin
				cand_start_d = now_s1;
				cand_d       = level_s1;
			end
		end else if (level_s1 == cand_q) begin
			if (cand_age > {16'd0, debounce_ms_q}) begin
				stable_d     = cand_q;
				cand_start_d = '0;
				if (level_s1 == idle_level_q) begin
					restart_fired_d = 1'b0;
					event_d         = bdpc_pkg::EV_RELEASE;
					short_d         = held < {16'd0, click_ms_q};
				end else begin
					press_start_d = now_s1;
					event_d       = bdpc_pkg::EV_PRESS;
				end
			end
		end else begin
			// bounce back cancels the candidate
			cand_d       = stable_q;
			cand_start_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q        <= 1'b1;
			cand_q          <= 1'b1;
			cand_start_q    <= '0;
			press_start_q   <= '0;
			restart_fired_q <= 1'b0;
		end else if (v_s1 && adv_s1) begin
			stable_q        <= stable_d;
			cand_q          <= cand_d;
			cand_start_q    <= cand_start_d;
			press_start_q   <= press_start_d;
			restart_fired_q <= restart_fired_d;
		end
	end

	// output register
	logic [1:0] event_q;
	logic       short_q;
	logic       pushed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv_s1) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && adv_s1) begin
			event_q  <= event_d;
			short_q  <= short_d;
			pushed_q <= stable_d != idle_level_q;
		end
	end

	assign out_ch.valid       = out_v_q;
	assign out_ch.event_code  = event_q;
	assign out_ch.short_click = short_q;
	assign out_ch.pushed      = pushed_q;

	// checks
	a_short_only_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && short_q |-> event_q == bdpc_pkg::EV_RELEASE)
		else $error("short click flagged on a non-release word");

	a_press_pushed: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && (event_q == bdpc_pkg::EV_PRESS || event_q == bdpc_pkg::EV_RESTART)
		|-> pushed_q)
		else $error("press or restart word without pushed");

	a_release_not_pushed: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && event_q == bdpc_pkg::EV_RELEASE |-> !pushed_q)
		else $error("release word still pushed");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && out_v_q && !out_ch.ready |-> !in_ch.ready)
		else $error("input accepted while both stages are full and stalled");

	a_restart_once: assert property (@(posedge clk) disable iff (!arst_n)
		restart_fired_q && v_s1 && adv_s1 |-> event_d != bdpc_pkg::EV_RESTART)
		else $error("second restart event within one press");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the button debounce and press classifier core.
// A queue-fed driver offers samples on in_ch; a clocked monitor predicts the
// event word for each sample taken and checks every word leaving out_ch.
// Phases cover the reset settings, the threshold extremes and random limits,
// each with a mix of sender gaps and receiver stalls, and one phase
// holds the receiver off long enough to back up the input side.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct packed {
		logic        level;
		logic [31:0] now;
	} sample_t;

	typedef struct packed {
		logic [1:0] ev;
		logic       click;
		logic       pushed;
	} press_evt_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [bdpc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bdpc_pkg::CFG_DATA_W-1:0] cfg_data;

	bdpc_in_if  in_ch ();
	bdpc_out_if out_ch ();

	button_debounce_press_classifier_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch.sink),
		.out_ch    (out_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// samples waiting to be offered, event words waiting to come out
	sample_t    sample_q[$];
	press_evt_t event_q[$];

	int unsigned gap_pct   = 0;
	int unsigned stall_pct = 0;
	int unsigned fail_cnt  = 0;
	logic        in_taken  = 1'b0;
	logic        hold_go   = 1'b0;
	logic        hold_on   = 1'b0;

	// predictor copy of the limits and the debounce state
	logic        idle_lvl;
	logic [15:0] debounce_lim;
	logic [15:0] click_lim;
	logic [31:0] restart_lim;
	logic        acc_lvl;
	logic        cand_lvl;
	logic [31:0] cand_t;
	logic [31:0] press_t;
	logic        restart_done;

	function automatic press_evt_t classify_sample(input logic lvl, input logic [31:0] now);
		press_evt_t  r;
		logic [31:0] held;
		logic [31:0] waited;
		r.ev     = bdpc_pkg::EV_NONE;
		r.click  = 1'b0;
		held     = now - press_t;
		waited   = now - cand_t;
		if (acc_lvl == cand_lvl) begin
			if (lvl == cand_lvl) begin
				if (lvl != idle_lvl && held > restart_lim && !restart_done) begin
					restart_done = 1'b1;
					r.ev         = bdpc_pkg::EV_RESTART;
				end
			end else begin
				cand_t   = now;
				cand_lvl = lvl;
			end
		end else if (lvl == cand_lvl) begin
			if (waited > {16'd0, debounce_lim}) begin
				acc_lvl = cand_lvl;
				cand_t  = '0;
				if (lvl == idle_lvl) begin
					restart_done = 1'b0;
					r.ev         = bdpc_pkg::EV_RELEASE;
					r.click      = (held < {16'd0, click_lim});
				end else begin
					press_t = now;
					r.ev    = bdpc_pkg::EV_PRESS;
				end
			end
		end else begin
			// bounced back to the accepted level
			cand_lvl = acc_lvl;
			cand_t   = '0;
		end
		r.pushed = (acc_lvl != idle_lvl);
		return r;
	endfunction

	task automatic note_failure(input string msg);
		if (fail_cnt < 10)
			$display("ERROR @%0t: %s", $realtime, msg);
		fail_cnt++;
	endtask

	// input side: a word stays on the bus until taken
	always @(negedge clk) begin : drive_samples
		sample_t w;
		if (arst_n && (!in_ch.valid || in_taken)) begin
			if (sample_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
				w = sample_q.pop_front();
				in_ch.valid        <= 1'b1;
				in_ch.sample_level <= w.level;
				in_ch.now_ms       <= w.now;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			out_ch.ready <= !hold_on && ($urandom_range(99) >= stall_pct);
	end

	// long receiver hold-off, once
	initial begin : hold_off
		int unsigned n;
		wait (hold_go);
		@(negedge clk);
		hold_on <= 1'b1;
		for (n = 0; n < 300; n++)
			@(negedge clk);
		hold_on <= 1'b0;
	end

	always @(posedge clk) begin : monitor
		press_evt_t got;
		press_evt_t want;
		if (arst_n) begin
			in_taken <= in_ch.valid && in_ch.ready;
			if (out_ch.valid && out_ch.ready) begin
				got.ev     = out_ch.event_code;
				got.click  = out_ch.short_click;
				got.pushed = out_ch.pushed;
				if (event_q.size() == 0) begin
					note_failure($sformatf("unexpected word ev=%0d click=%0d pushed=%0d",
						got.ev, got.click, got.pushed));
				end else begin
					want = event_q.pop_front();
					if (got.ev !== want.ev || got.click !== want.click ||
						got.pushed !== want.pushed)
						note_failure($sformatf(
							"exp ev=%0d click=%0d pushed=%0d, got ev=%0d click=%0d pushed=%0d",
							want.ev, want.click, want.pushed, got.ev, got.click, got.pushed));
				end
			end
			if (in_ch.valid && in_ch.ready)
				event_q.push_back(classify_sample(in_ch.sample_level, in_ch.now_ms));
		end
	end

	task automatic cfg_write(input logic [bdpc_pkg::CFG_IDX_W-1:0] idx,
		input logic [31:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			bdpc_pkg::REG_IDLE_LEVEL:  idle_lvl     = val[0];
			bdpc_pkg::REG_DEBOUNCE_MS: debounce_lim = val[15:0];
			bdpc_pkg::REG_CLICK_MS:    click_lim    = val[15:0];
			bdpc_pkg::REG_RESTART_MS:  restart_lim  = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// narrow registers get random upper bits, which must be dropped
	task automatic program_limits(input logic idle, input logic [15:0] dbc,
		input logic [15:0] clk_lim, input logic [31:0] rst_lim);
		logic [31:0] junk;
		junk = $urandom();
		cfg_write(bdpc_pkg::REG_IDLE_LEVEL, {junk[31:1], idle});
		junk = $urandom();
		cfg_write(bdpc_pkg::REG_DEBOUNCE_MS, {junk[31:16], dbc});
		junk = $urandom();
		cfg_write(bdpc_pkg::REG_CLICK_MS, {junk[31:16], clk_lim});
		cfg_write(bdpc_pkg::REG_RESTART_MS, rst_lim);
	endtask

	task automatic queue_sample(input logic lvl, input logic [31:0] now);
		sample_q.push_back('{level: lvl, now: now});
	endtask

	// checked at the rising edge, where the driver's outputs are settled
	task automatic drain;
		while (sample_q.size() != 0 || in_ch.valid || event_q.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// button presses with bounce, near-threshold timing and long holds
	task automatic queue_presses(input int unsigned n);
		logic             btn;
		logic [31:0]      stamp;
		logic [31:0]      dt;
		longint unsigned  span;
		int unsigned      i;
		int unsigned      r;
		btn   = 1'($urandom_range(1));
		stamp = $urandom();
		for (i = 0; i < n; i++) begin
			if ($urandom_range(99) < 12)
				btn = ~btn;
			r = $urandom_range(99);
			if (r < 50) begin
				dt = $urandom_range(debounce_lim / 2 + 2);
			end else if (r < 85) begin
				dt = debounce_lim + $urandom_range(2);
			end else if (r < 95) begin
				dt = $urandom_range(2 * click_lim + 10);
			end else begin
				span = longint'(restart_lim) + restart_lim / 4 + 2;
				if (span > 64'hFFFF_FFFF)
					span = 64'hFFFF_FFFF;
				dt = $urandom_range(span[31:0]);
			end
			if ($urandom_range(99) == 0)
				stamp = $urandom();
			else
				stamp = stamp + dt;
			queue_sample(($urandom_range(99) < 8) ? ~btn : btn, stamp);
		end
	endtask

	initial begin : main
		int unsigned p;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = bdpc_pkg::REG_IDLE_LEVEL;
		cfg_data           = '0;
		in_ch.valid        = 1'b0;
		in_ch.sample_level = 1'b0;
		in_ch.now_ms       = '0;
		out_ch.ready       = 1'b0;
		idle_lvl     = bdpc_pkg::IDLE_LEVEL_RST;
		debounce_lim = bdpc_pkg::DEBOUNCE_MS_RST;
		click_lim    = bdpc_pkg::CLICK_MS_RST;
		restart_lim  = bdpc_pkg::RESTART_MS_RST;
		acc_lvl      = 1'b1;
		cand_lvl     = 1'b1;
		cand_t       = '0;
		press_t      = '0;
		restart_done = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset limits: debounce 20, click 400, restart 15000
		gap_pct   = 16;
		stall_pct = 16;
		queue_sample(1'b1, 32'd5);
		queue_sample(1'b0, 32'd100);
		queue_sample(1'b1, 32'd105);          // bounce cancels candidate
		queue_sample(1'b0, 32'd110);
		queue_sample(1'b0, 32'd130);          // exactly debounce: not yet
		queue_sample(1'b0, 32'd131);          // press
		queue_sample(1'b0, 32'd200);
		queue_sample(1'b1, 32'd250);
		queue_sample(1'b1, 32'd271);          // short click release
		queue_sample(1'b0, 32'd300);
		queue_sample(1'b0, 32'd321);
		queue_sample(1'b0, 32'd15321);        // held exactly restart
		queue_sample(1'b0, 32'd15322);        // restart
		queue_sample(1'b0, 32'd20000);        // no second restart
		queue_sample(1'b1, 32'd20010);
		queue_sample(1'b0, 32'd20015);        // bounce while pressed
		queue_sample(1'b1, 32'd20020);
		queue_sample(1'b1, 32'd20041);        // long release
		queue_sample(1'b0, 32'hFFFF_FFFF);    // candidate across the wrap
		queue_sample(1'b0, 32'h0000_0014);
		queue_sample(1'b1, 32'h0000_0020);
		queue_sample(1'b1, 32'h0000_0035);
		drain();

		// idle level flips under a held state; zero debounce
		program_limits(1'b0, 16'd0, bdpc_pkg::CLICK_MS_RST, bdpc_pkg::RESTART_MS_RST);
		queue_sample(1'b0, 32'd50);
		queue_sample(1'b0, 32'd50);           // zero elapsed is not > 0
		queue_sample(1'b0, 32'd51);           // release with stale press time
		drain();

		for (p = 0; p < 8; p++) begin
			case (p)
				0: program_limits(1'b0, 16'd0, 16'hFFFF, 32'd0);
				1: program_limits(1'b1, 16'hFFFF, 16'd0, 32'hFFFF_FFFF);
				default: program_limits(1'($urandom_range(1)), 16'($urandom_range(40)),
					16'($urandom_range(300)), $urandom_range(600));
			endcase
			case (p % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 51; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 51; end
				default: begin gap_pct = 16; stall_pct = 16; end
			endcase
			if (p == 4)
				hold_go = 1'b1;
			queue_presses(50);
			drain();
		end

		repeat (10) @(negedge clk);
		if (fail_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
